[hdl/assert_macros.svh]
// Assertion macros shared by the resampler RTL.
// Expects a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled in reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define ASSERT_IMPLIES(lbl, cond, expr, msg) \
  `ASSERT_CLK(lbl, (cond) |-> (expr), msg)

// Next-cycle implication built on the first macro.
`define ASSERT_NEXT(lbl, cond, expr, msg) \
  `ASSERT_CLK(lbl, (cond) |=> (expr), msg)

`endif

[hdl/splr_pkg.sv]
// Package for the sample player linear resampler core.
// Holds sizing constants, command and register codes and stage types; no dependencies.
package splr_pkg;

  localparam int MAX_FRAMES    = 65536;
  localparam int CHANNELS      = 2;
  localparam int FRACTION_BITS = 16;

  localparam int SAMPLE_W   = 16;
  localparam int POS_W      = 32;
  localparam int SRC_W      = 49;
  localparam int FC_CFG_W   = 17;
  localparam int RATE_W     = 20;
  localparam int NCH_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ADDR_W     = 16;
  localparam int OUT_CH     = 2;

  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int FC_W       = $clog2(MAX_FRAMES + 1);
  localparam int BANK_DEPTH = (MAX_FRAMES + 1) / 2;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int STORE_CH   = (CHANNELS < OUT_CH) ? CHANNELS : OUT_CH;
  localparam int PROD_W     = FRACTION_BITS + SAMPLE_W + 2;
  localparam int SEEK_W     = POS_W + RATE_W + 1;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);
  localparam logic [31:0]       UNITY_RATE = 32'd1 << FRACTION_BITS;
  localparam logic [PROD_W:0]   ROUND_HALF = (PROD_W + 1)'(1) << (FRACTION_BITS - 1);
  localparam logic [SRC_W-1:0]  SRC_MAX    = {1'b0, {(SRC_W - 1){1'b1}}};
  localparam logic [SRC_W-1:0]  SRC_MIN    = {1'b1, {(SRC_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_SEEK  = 2'd1,
    CMD_FRAME = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_COUNT    = 3'd0,
    CFG_RATE_INCREMENT = 3'd1,
    CFG_CHANNEL_COUNT  = 3'd2,
    CFG_PLAYING        = 3'd3,
    CFG_BYPASS         = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                     active;
    logic [OUT_CH-1:0]        mask;
    logic [FRACTION_BITS-1:0] frac;
    logic                     odd;
    logic [POS_W-1:0]         pos;
  } frame_ctrl_t;

endpackage

[hdl/sample_player_linear_resampler_core.sv]
// Sample player with linear-interpolation resampler, top level.
// Depends on splr_pkg and assert_macros.svh.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         tvalid / tready           tdata, tuser (command, channel)
//   m_axis    out        tvalid / tready           tdata, tuser (active)
//   cfg       in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One transaction is accepted per cycle while s_axis_tready_o is high; a frame result
// passes the input register, the state update with banked store read, the product
// register and the result register. Even and odd frames sit in separate store banks, so
// both neighbors of a source position are read in the same cycle.
// Reset clears positions and registers only; store entries are undefined until loaded.
// Backpressure on m_axis fills the stages in turn before s_axis_tready_o drops.
`include "assert_macros.svh"

module sample_player_linear_resampler_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] address, [31:16] sample, [63:32] seek_position
  input  logic [63:0]                      s_axis_tdata_i,
  // [1:0] command, [2] channel
  input  logic [2:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [15:0] sample_ch0, [31:16] sample_ch1, [63:32] position
  output logic [63:0]                      m_axis_tdata_o,
  // [0] active
  output logic [0:0]                       m_axis_tuser_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [splr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [splr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int SW  = splr_pkg::SAMPLE_W;
  localparam int FB  = splr_pkg::FRACTION_BITS;
  localparam int NCH = splr_pkg::OUT_CH;

  // Configuration registers.
  logic [splr_pkg::FC_CFG_W-1:0] cfg_fc_q;
  logic [splr_pkg::RATE_W-1:0]   cfg_rate_q;
  logic [splr_pkg::NCH_W-1:0]    cfg_nch_q;
  logic                          cfg_play_q;
  logic                          cfg_bypass_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_fc_q     <= '0;
      cfg_rate_q   <= splr_pkg::RATE_RESET;
      cfg_nch_q    <= splr_pkg::NCH_W'(2);
      cfg_play_q   <= 1'b0;
      cfg_bypass_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (splr_pkg::cfg_idx_e'(cfg_index_i))
        splr_pkg::CFG_FRAME_COUNT:    cfg_fc_q     <= cfg_data_i[splr_pkg::FC_CFG_W-1:0];
        splr_pkg::CFG_RATE_INCREMENT: cfg_rate_q   <= cfg_data_i[splr_pkg::RATE_W-1:0];
        splr_pkg::CFG_CHANNEL_COUNT:  cfg_nch_q    <= cfg_data_i[splr_pkg::NCH_W-1:0];
        splr_pkg::CFG_PLAYING:        cfg_play_q   <= cfg_data_i[0];
        splr_pkg::CFG_BYPASS:         cfg_bypass_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Stage handshakes.
  logic a_valid_q, c_valid_q, d_valid_q, o_valid_q;
  logic b_go, c_go, o_go, b_frame, b_load;

  assign o_go            = d_valid_q && (!o_valid_q || m_axis_tready_i);
  assign c_go            = c_valid_q && (!d_valid_q || o_go);
  assign b_go            = a_valid_q && (!b_frame || !c_valid_q || c_go);
  assign s_axis_tready_o = !a_valid_q || b_go;

  // Input register.
  logic [63:0] a_data_q;
  logic [2:0]  a_user_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      a_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      a_data_q <= s_axis_tdata_i;
      a_user_q <= s_axis_tuser_i;
    end
  end

  logic [splr_pkg::ADDR_W-1:0] a_addr;
  logic [SW-1:0]               a_sample;
  logic [splr_pkg::POS_W-1:0]  a_seek;
  logic                        a_chan;

  assign a_addr   = a_data_q[15:0];
  assign a_sample = a_data_q[31:16];
  assign a_seek   = a_data_q[63:32];
  assign a_chan   = a_user_q[2];

  // Playback state and command processing.
  logic        [splr_pkg::POS_W-1:0] pos_q, pos_d;
  logic signed [splr_pkg::SRC_W-1:0] src_q, src_d;

  logic        [splr_pkg::FC_W-1:0]   fc;
  logic        [splr_pkg::NCH_W-1:0]  nch;
  logic        [NCH-1:0]              ch_mask;
  logic        [splr_pkg::SRC_W-1:0]  fc_ext;
  logic signed [splr_pkg::SRC_W-1:0]  limit;
  logic signed [splr_pkg::SEEK_W-1:0] seek_prod;
  logic signed [splr_pkg::SRC_W-1:0]  seek_sat;
  logic        [splr_pkg::SEEK_W-splr_pkg::SRC_W:0] seek_top;
  logic signed [splr_pkg::SRC_W:0]    adv_sum;
  logic signed [splr_pkg::SRC_W-1:0]  adv_sat;
  logic                               is_unity, pos_hit, run;
  logic        [splr_pkg::FRAME_W-1:0] b_idx;
  logic        [splr_pkg::FRAME_W:0]   b_idx_p1;
  splr_pkg::frame_ctrl_t              b_ctrl;

  always_comb begin
    fc = (32'(cfg_fc_q) > 32'(splr_pkg::MAX_FRAMES)) ? splr_pkg::FC_W'(splr_pkg::MAX_FRAMES)
                                                       : splr_pkg::FC_W'(cfg_fc_q);
    nch = (32'(cfg_nch_q) > 32'(splr_pkg::STORE_CH)) ? splr_pkg::NCH_W'(splr_pkg::STORE_CH)
                                                       : cfg_nch_q;
    for (int c = 0; c < NCH; c++) begin
      ch_mask[c] = (32'(c) < 32'(nch));
    end
    fc_ext   = splr_pkg::SRC_W'(fc);
    limit    = $signed(fc_ext - splr_pkg::SRC_W'(1)) <<< FB;
    is_unity = (32'(cfg_rate_q) == splr_pkg::UNITY_RATE);
    pos_hit  = !pos_q[splr_pkg::POS_W-1] && (pos_q < 32'(fc));
    run      = cfg_play_q && !cfg_bypass_q;

    seek_prod = $signed(a_seek) * $signed({1'b0, cfg_rate_q});
    seek_top  = seek_prod[splr_pkg::SEEK_W-1:splr_pkg::SRC_W-1];
    if ((&seek_top) || !(|seek_top)) begin
      seek_sat = seek_prod[splr_pkg::SRC_W-1:0];
    end else if (seek_prod[splr_pkg::SEEK_W-1]) begin
      seek_sat = splr_pkg::SRC_MIN;
    end else begin
      seek_sat = splr_pkg::SRC_MAX;
    end

    adv_sum = $signed({src_q[splr_pkg::SRC_W-1], src_q})
              + $signed((splr_pkg::SRC_W + 1)'(cfg_rate_q));
    adv_sat = (adv_sum[splr_pkg::SRC_W] != adv_sum[splr_pkg::SRC_W-1]) ? splr_pkg::SRC_MAX
                                                                        : adv_sum[splr_pkg::SRC_W-1:0];
  end

  always_comb begin
    pos_d   = pos_q;
    src_d   = src_q;
    b_frame = 1'b0;
    b_load  = 1'b0;
    b_idx   = '0;
    b_ctrl  = '0;
    case (splr_pkg::cmd_e'(a_user_q[1:0]))
      splr_pkg::CMD_LOAD: begin
        b_load = 1'b1;
      end
      splr_pkg::CMD_SEEK: begin
        pos_d = a_seek;
        src_d = seek_sat;
      end
      splr_pkg::CMD_FRAME: begin
        b_frame = 1'b1;
        if (run) begin
          if (is_unity) begin
            if (pos_hit) begin
              b_ctrl.active = 1'b1;
              b_ctrl.mask   = ch_mask;
              b_idx         = pos_q[splr_pkg::FRAME_W-1:0];
              pos_d         = pos_q + 32'd1;
            end
          end else if (src_q < limit) begin
            b_ctrl.active = 1'b1;
            if (!src_q[splr_pkg::SRC_W-1]) begin
              b_ctrl.mask = ch_mask;
              b_ctrl.frac = src_q[FB-1:0];
              b_idx       = src_q[FB +: splr_pkg::FRAME_W];
            end
            src_d = adv_sat;
            pos_d = pos_q + 32'd1;
          end
        end
        b_ctrl.pos = pos_d;
      end
      default: ;
    endcase
    b_ctrl.odd = b_idx[0];
  end

  assign b_idx_p1 = {1'b0, b_idx} + (splr_pkg::FRAME_W + 1)'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      src_q <= '0;
    end else if (b_go) begin
      pos_q <= pos_d;
      src_q <= src_d;
    end
  end

  // Banked sample store: even frames in one bank, odd frames in the other.
  logic [splr_pkg::BANK_AW-1:0] wr_addr, rd_even, rd_odd;
  logic                         addr_ok, rd_en;
  logic [SW-1:0]                c_even_q [NCH];
  logic [SW-1:0]                c_odd_q  [NCH];

  assign wr_addr = splr_pkg::BANK_AW'(a_addr[splr_pkg::ADDR_W-1:1]);
  assign rd_even = splr_pkg::BANK_AW'(b_idx_p1 >> 1);
  assign rd_odd  = splr_pkg::BANK_AW'(b_idx >> 1);
  assign addr_ok = (32'(a_addr) < 32'(splr_pkg::MAX_FRAMES));
  assign rd_en   = b_go && b_frame;

  for (genvar c = 0; c < NCH; c++) begin : g_store
    if (c < splr_pkg::STORE_CH) begin : g_mem
      logic [SW-1:0] even_mem [splr_pkg::BANK_DEPTH];
      logic [SW-1:0] odd_mem  [splr_pkg::BANK_DEPTH];
      logic          we;

      assign we = b_go && b_load && addr_ok && (a_chan == 1'(c));

      always_ff @(posedge clk_i) begin
        if (we && !a_addr[0]) begin
          even_mem[wr_addr] <= a_sample;
        end
        if (rd_en) begin
          c_even_q[c] <= even_mem[rd_even];
        end
      end

      always_ff @(posedge clk_i) begin
        if (we && a_addr[0]) begin
          odd_mem[wr_addr] <= a_sample;
        end
        if (rd_en) begin
          c_odd_q[c] <= odd_mem[rd_odd];
        end
      end
    end else begin : g_none
      assign c_even_q[c] = '0;
      assign c_odd_q[c]  = '0;
    end
  end

  splr_pkg::frame_ctrl_t c_ctrl_q, d_ctrl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (rd_en) begin
      c_valid_q <= 1'b1;
    end else if (c_go) begin
      c_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      c_ctrl_q <= b_ctrl;
    end
  end

  // Interpolation product.
  logic signed [SW-1:0]       s0 [NCH];
  logic signed [SW-1:0]       s1 [NCH];
  logic signed [SW:0]         diff [NCH];
  logic signed [PROD_W_L-1:0] prod [NCH];
  localparam int PROD_W_L = splr_pkg::PROD_W;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      s0[c]   = c_ctrl_q.odd ? c_odd_q[c] : c_even_q[c];
      s1[c]   = c_ctrl_q.odd ? c_even_q[c] : c_odd_q[c];
      diff[c] = $signed({s1[c][SW-1], s1[c]}) - $signed({s0[c][SW-1], s0[c]});
      prod[c] = $signed({1'b0, c_ctrl_q.frac}) * diff[c];
    end
  end

  logic signed [PROD_W_L-1:0] d_prod_q [NCH];
  logic signed [SW-1:0]       d_s0_q   [NCH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (c_go) begin
      d_valid_q <= 1'b1;
    end else if (o_go) begin
      d_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_go) begin
      d_ctrl_q <= c_ctrl_q;
      for (int c = 0; c < NCH; c++) begin
        d_prod_q[c] <= prod[c];
        d_s0_q[c]   <= s0[c];
      end
    end
  end

  // Rounding, offset add and result register.
  logic signed [PROD_W_L:0] t    [NCH];
  logic signed [PROD_W_L:0] tsh  [NCH];
  logic signed [SW+1:0]     osum [NCH];
  logic        [SW-1:0]     res  [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      t[c]    = $signed({d_prod_q[c][PROD_W_L-1], d_prod_q[c]})
                + $signed(splr_pkg::ROUND_HALF);
      tsh[c]  = t[c] >>> FB;
      osum[c] = $signed({{2{d_s0_q[c][SW-1]}}, d_s0_q[c]}) + tsh[c][SW+1:0];
      res[c]  = d_ctrl_q.mask[c] ? osum[c][SW-1:0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_go) begin
      o_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      o_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_go) begin
      m_axis_tdata_o <= {d_ctrl_q.pos, res[1], res[0]};
      m_axis_tuser_o <= d_ctrl_q.active;
    end
  end

  assign m_axis_tvalid_o = o_valid_q;

  `ASSERT_IMPLIES(a_idle_silent, m_axis_tvalid_o && !m_axis_tuser_o[0],
                  m_axis_tdata_o[31:0] == '0, "inactive frame carries nonzero samples")
  `ASSERT_NEXT(a_pos_advance, b_go && b_frame && b_ctrl.active,
               pos_q == $past(pos_q) + 32'd1, "played frame did not advance position")
  `ASSERT_IMPLIES(a_mask_active, c_valid_q && !c_ctrl_q.active,
                  c_ctrl_q.mask == '0, "inactive frame enables a channel")

endmodule

[test/sample_player_linear_resampler_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sample_player_linear_resampler_core: streams load, seek
// and frame commands, predicts each frame and compares it with the output stream.
// Depends on splr_pkg and the core RTL.
module sample_player_linear_resampler_core_test;
  import splr_pkg::*;

  localparam logic [1:0] CMD_NOP      = 2'd3;
  localparam int         RUN_LIMIT    = 500000;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         PHASES       = 14;
  localparam int         PRINT_CAP    = 40;
  localparam longint     SRC_TOP      = (longint'(1) <<< (SRC_W - 1)) - 1;
  localparam longint     SRC_BOTTOM   = -(longint'(1) <<< (SRC_W - 1));

  typedef struct packed {
    logic [1:0]  cmd;
    logic        chan;
    logic [15:0] addr;
    logic [15:0] smp;
    logic [31:0] seek;
  } player_cmd_t;

  typedef struct packed {
    logic [15:0] ch0;
    logic [15:0] ch1;
    logic        active;
    logic [31:0] position;
  } frame_t;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [63:0]           s_axis_tdata_i  = '0;
  logic [2:0]            s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [63:0]           m_axis_tdata_o;
  logic [0:0]            m_axis_tuser_o;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  sample_player_linear_resampler_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // Player state as the block should hold it.
  logic signed [15:0]       pcm_mem [0:1][0:MAX_FRAMES-1];
  logic [31:0]              play_pos    = '0;
  logic signed [SRC_W-1:0]  src_pos     = '0;
  logic [FC_CFG_W-1:0]      reg_frames  = '0;
  logic [RATE_W-1:0]        reg_rate    = RATE_RESET;
  logic [NCH_W-1:0]         reg_chans   = 2'd2;
  logic                     reg_playing = 1'b0;
  logic                     reg_bypass  = 1'b0;

  // Entries the stimulus has loaded so far; frames never read any other entry.
  bit                       loaded [0:1][0:MAX_FRAMES-1];

  player_cmd_t pending_cmds[$];
  frame_t      frames_due[$];
  int          queued_count   = 0;
  int          accepted_count = 0;
  int          frames_checked = 0;
  int          mismatch_count = 0;
  int          settings_count = 0;
  int          cycle_count    = 0;
  int          idle_pct       = 0;
  int          send_gap       = 0;
  int          hold_gap       = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic longint clip_src(input longint v);
    if (v > SRC_TOP) return SRC_TOP;
    if (v < SRC_BOTTOM) return SRC_BOTTOM;
    return v;
  endfunction

  function automatic frame_t render_frame();
    frame_t      f;
    int          fc;
    int          nch;
    longint      sp;
    longint      lim;
    longint      frac;
    longint      s0;
    longint      s1;
    longint      t;
    logic [15:0] idx;
    logic [15:0] outs [0:1];
    f       = '0;
    outs[0] = '0;
    outs[1] = '0;
    fc  = (reg_frames > MAX_FRAMES) ? MAX_FRAMES : int'(reg_frames);
    nch = (reg_chans < CHANNELS) ? int'(reg_chans) : CHANNELS;
    if (reg_playing && !reg_bypass) begin
      if (32'(reg_rate) == UNITY_RATE) begin
        if (!play_pos[31] && longint'(play_pos) < longint'(fc)) begin
          for (int ch = 0; ch < nch; ch++) outs[ch] = pcm_mem[ch][play_pos[15:0]];
          play_pos = play_pos + 32'd1;
          f.active = 1'b1;
        end
      end else begin
        sp  = src_pos;
        lim = longint'(fc - 1) <<< FRACTION_BITS;
        if (sp < lim) begin
          if (sp >= 0) begin
            idx  = 16'(sp >>> FRACTION_BITS);
            frac = sp & ((longint'(1) <<< FRACTION_BITS) - 1);
            for (int ch = 0; ch < nch; ch++) begin
              s0 = pcm_mem[ch][idx];
              s1 = pcm_mem[ch][idx + 16'd1];
              t  = frac * (s1 - s0) + (longint'(1) <<< (FRACTION_BITS - 1));
              outs[ch] = 16'(s0 + (t >>> FRACTION_BITS));
            end
          end
          src_pos  = SRC_W'(clip_src(sp + longint'(reg_rate)));
          play_pos = play_pos + 32'd1;
          f.active = 1'b1;
        end
      end
    end
    f.ch0      = outs[0];
    f.ch1      = outs[1];
    f.position = play_pos;
    return f;
  endfunction

  function automatic void apply_command(input player_cmd_t c);
    case (c.cmd)
      CMD_LOAD: pcm_mem[c.chan][c.addr] = c.smp;
      CMD_SEEK: begin
        play_pos = c.seek;
        src_pos  = SRC_W'(clip_src(longint'($signed(c.seek)) * longint'(reg_rate)));
      end
      CMD_FRAME: frames_due.push_back(render_frame());
      default: ;
    endcase
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    case (idx)
      CFG_FRAME_COUNT:    reg_frames  = val[FC_CFG_W-1:0];
      CFG_RATE_INCREMENT: reg_rate    = val[RATE_W-1:0];
      CFG_CHANNEL_COUNT:  reg_chans   = val[NCH_W-1:0];
      CFG_PLAYING:        reg_playing = val[0];
      CFG_BYPASS:         reg_bypass  = val[0];
      default: ;
    endcase
  endfunction

  task automatic check_frame(input logic [63:0] data, input logic active);
    frame_t want;
    if (frames_due.size() == 0) begin
      flag_mismatch($sformatf("frame with no command pending: data %h", data));
      return;
    end
    want = frames_due.pop_front();
    frames_checked++;
    if (data[15:0] !== want.ch0)
      flag_mismatch($sformatf("sample_ch0 %h, want %h", data[15:0], want.ch0));
    if (data[31:16] !== want.ch1)
      flag_mismatch($sformatf("sample_ch1 %h, want %h", data[31:16], want.ch1));
    if (active !== want.active)
      flag_mismatch($sformatf("active %b, want %b", active, want.active));
    if (data[63:32] !== want.position)
      flag_mismatch($sformatf("position %h, want %h", data[63:32], want.position));
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] with_junk(input logic [31:0] val, input int width);
    logic [31:0] v;
    v = val;
    if ($urandom_range(0, 1) == 1)
      for (int b = width; b < 32; b++) v[b] = 1'($urandom);
    return v;
  endfunction

  task automatic queue_load(input logic chan, input logic [15:0] addr, input logic [15:0] smp);
    pending_cmds.push_back({CMD_LOAD, chan, addr, smp, 32'($urandom)});
    queued_count++;
    loaded[chan][addr] = 1'b1;
  endtask

  task automatic queue_cmd(input logic [1:0] cmd, input logic [31:0] seek);
    pending_cmds.push_back({cmd, 1'($urandom), 16'($urandom), 16'($urandom), seek});
    queued_count++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    while (accepted_count != queued_count || frames_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    player_cmd_t nxt;
    if (rst_ni && (!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        send_gap = $urandom_range(0, 7);
        s_axis_tvalid_i <= 1'b0;
      end else begin
        nxt = pending_cmds.pop_front();
        s_axis_tdata_i  <= {nxt.seek, nxt.smp, nxt.addr};
        s_axis_tuser_i  <= {nxt.chan, nxt.cmd};
        s_axis_tvalid_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_gap > 0) begin
        hold_gap--;
        m_axis_tready_i <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        hold_gap = $urandom_range(0, 7);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        apply_command({s_axis_tuser_i[1:0], s_axis_tuser_i[2], s_axis_tdata_i[15:0],
                       s_axis_tdata_i[31:16], s_axis_tdata_i[63:32]});
        accepted_count++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) check_frame(m_axis_tdata_o, m_axis_tuser_o[0]);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("sample_player_linear_resampler_core regression: fail");
      $finish;
    end
  end

  initial begin
    int     fc_eff;
    int     fc_cfg;
    int     chans_cfg;
    int     count;
    int     lo;
    int     hi;
    int     pick;
    int     max_seek;
    longint p;
    longint sp0;
    longint rate_now;
    logic   play_cfg;
    logic   byp_cfg;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unity rate: direct copies, running past the end, a negative position, a stray code.
    idle_pct = 20;
    write_reg(CFG_FRAME_COUNT, 32'd4);
    write_reg(CFG_PLAYING, 32'd1);
    settings_count++;
    queue_load(1'b0, 16'd0, 16'h8000);
    queue_load(1'b1, 16'd0, 16'h7FFF);
    queue_load(1'b0, 16'd1, 16'h7FFF);
    queue_load(1'b1, 16'd1, 16'h8000);
    queue_load(1'b0, 16'd2, 16'h0000);
    queue_load(1'b1, 16'd2, 16'h0001);
    queue_load(1'b0, 16'd3, 16'h0001);
    queue_load(1'b1, 16'd3, 16'h0000);
    queue_load(1'b1, 16'hFFFF, 16'h5A5A);
    repeat (5) queue_cmd(CMD_FRAME, 32'($urandom));
    queue_cmd(CMD_SEEK, 32'hFFFF_FFFF);
    queue_cmd(CMD_FRAME, 32'($urandom));
    queue_cmd(CMD_NOP, 32'($urandom));
    settle();

    // Half rate: midpoints between full-scale neighbors, the end of the store,
    // a negative source position and the largest and smallest seek positions.
    write_reg(CFG_RATE_INCREMENT, 32'd32768);
    settings_count++;
    queue_cmd(CMD_SEEK, 32'd0);
    repeat (6) queue_cmd(CMD_FRAME, 32'($urandom));
    queue_cmd(CMD_SEEK, 32'hFFFF_FFFF);
    repeat (2) queue_cmd(CMD_FRAME, 32'($urandom));
    queue_cmd(CMD_SEEK, 32'h7FFF_FFFF);
    queue_cmd(CMD_FRAME, 32'($urandom));
    queue_cmd(CMD_SEEK, 32'h8000_0000);
    queue_cmd(CMD_FRAME, 32'($urandom));
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      fc_cfg    = $urandom_range(2, 24);
      chans_cfg = $urandom_range(1, 2);
      play_cfg  = 1'b1;
      byp_cfg   = 1'b0;
      case ($urandom_range(0, 3))
        0: rate_now = 65536;
        1: rate_now = $urandom_range(16384, 131072);
        2: rate_now = $urandom_range(1, 1048575);
        default: rate_now = 65536 + $urandom_range(0, 6) - 3;
      endcase
      case (ph)
        0: begin
          fc_cfg   = 131071;
          rate_now = 65536;
        end
        1: begin
          fc_cfg   = 65536;
          rate_now = $urandom_range(20000, 120000);
          if (rate_now == 65536) rate_now = 65537;
        end
        2: fc_cfg = 0;
        3: begin
          fc_cfg    = 1;
          chans_cfg = 0;
        end
        4: begin
          rate_now  = 0;
          chans_cfg = 3;
        end
        5: rate_now = 1;
        6: begin
          rate_now = 1048575;
          fc_cfg   = 32;
        end
        7: byp_cfg = 1'b1;
        8: play_cfg = 1'b0;
        default: ;
      endcase
      idle_pct = (ph >= PHASES - 2 || ph % 4 == 3) ? 0 : $urandom_range(5, 30);

      write_reg(CFG_FRAME_COUNT, with_junk(32'(fc_cfg), FC_CFG_W));
      write_reg(CFG_RATE_INCREMENT, with_junk(32'(rate_now), RATE_W));
      write_reg(CFG_CHANNEL_COUNT, with_junk(32'(chans_cfg), NCH_W));
      write_reg(CFG_PLAYING, with_junk({31'd0, play_cfg}, 1));
      write_reg(CFG_BYPASS, with_junk({31'd0, byp_cfg}, 1));
      settings_count++;
      fc_eff = (fc_cfg > MAX_FRAMES) ? MAX_FRAMES : fc_cfg;

      if (fc_eff > 64) begin
        // Large store: short runs after a seek, mostly close to the end, with the
        // frames that a run can reach loaded just before it.
        for (int r = 0; r < 14; r++) begin
          count = $urandom_range(1, 6);
          if ($urandom_range(0, 3) == 0)
            p = $urandom_range(0, fc_eff - 1);
          else
            p = ((longint'(fc_eff - 1) <<< FRACTION_BITS) / rate_now)
                + $urandom_range(0, 9) - 6;
          sp0 = p * rate_now;
          lo  = (sp0 < 0) ? 0 : int'(sp0 >>> FRACTION_BITS);
          hi  = int'((sp0 + (count - 1) * rate_now) >>> FRACTION_BITS) + 1;
          if (hi > fc_eff - 1) hi = fc_eff - 1;
          for (int a = lo; a <= hi; a++)
            for (int c = 0; c < 2; c++)
              if (!loaded[c][a]) queue_load(1'(c), 16'(a), pick_sample());
          queue_cmd(CMD_SEEK, 32'(p));
          repeat (count) queue_cmd(CMD_FRAME, 32'($urandom));
          if ($urandom_range(0, 2) == 0) queue_load(1'($urandom), 16'($urandom), pick_sample());
          if ($urandom_range(0, 4) == 0) queue_cmd(CMD_NOP, 32'($urandom));
        end
      end else begin
        for (int a = 0; a < fc_eff; a++)
          for (int c = 0; c < 2; c++)
            if (!loaded[c][a]) queue_load(1'(c), 16'(a), pick_sample());
        max_seek = (rate_now > 0 && fc_eff > 1)
                   ? int'((longint'(fc_eff - 1) <<< FRACTION_BITS) / rate_now) : fc_eff;
        for (int k = 0; k < 90; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 48) begin
            queue_cmd(CMD_FRAME, 32'($urandom));
          end else if (pick < 63) begin
            if ($urandom_range(0, 9) == 0)
              queue_cmd(CMD_SEEK, 32'($urandom));
            else
              queue_cmd(CMD_SEEK, 32'(longint'($urandom_range(0, max_seek + 6)) - 4));
          end else if (pick < 92) begin
            if ($urandom_range(0, 3) == 0)
              queue_load(1'($urandom), 16'($urandom), pick_sample());
            else
              queue_load(1'($urandom), 16'($urandom_range(0, fc_eff + 3)), pick_sample());
          end else begin
            queue_cmd(CMD_NOP, 32'($urandom));
          end
        end
      end
      settle();
    end

    for (int n = 0; n < 4000 && frames_due.size() != 0; n++) @(posedge clk_i);
    if (frames_due.size() != 0)
      flag_mismatch($sformatf("%0d frames never came out", frames_due.size()));
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d commands through %0d register settings, %0d frames compared.",
             accepted_count, settings_count, frames_checked);
    $display("Mismatches counted: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("sample_player_linear_resampler_core regression: pass");
    end else begin
      $display("sample_player_linear_resampler_core regression: fail");
    end
    $finish;
  end

endmodule
